FILE: sv/ccs_pkg.sv
// constants, stage map and helper functions for the cone/clock stereographic block
// no dependencies
`timescale 1ns / 1ps

package ccs_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int OUT_FRAC_BITS = 12;

    localparam int ANG_W  = 15;
    localparam int CLK_W  = 16;
    localparam int OUT_W  = 20;
    localparam int AW     = 34;
    localparam int TW     = 32;
    localparam int UW     = 33;
    localparam int DW     = 32;
    localparam int QB     = OUT_W + 1;
    localparam int RW     = DW + QB;

    localparam int ST_INIT  = 1;
    localparam int ST_TRIG  = CORDIC_STEPS + 2;
    localparam int ST_PROD  = CORDIC_STEPS + 3;
    localparam int ST_DIV0  = CORDIC_STEPS + 4;
    localparam int ST_OUT   = ST_DIV0 + QB + 1;
    localparam int N_STAGES = ST_OUT + 1;

    localparam logic [ANG_W-1:0] MAX_EXC_RESET = 15'd25736;

    localparam logic signed [AW-1:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [AW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [AW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [AW-1:0] Q30_TWO_PI  = 34'sd6746518852;
    localparam logic signed [AW-1:0] Q30_GAIN    = 34'sd652032874;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sh7FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 20'sh80000;

    function automatic logic signed [AW-1:0] atan_q30(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default: v = (i <= 30) ? AW'(64'sd1 << (30 - i)) : '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [AW-1:0] wrap_2pi(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] v;
        if (a > Q30_PI) begin
            v = a - Q30_TWO_PI;
        end else if (a < -Q30_PI) begin
            v = a + Q30_TWO_PI;
        end else begin
            v = a;
        end
        return v;
    endfunction

endpackage

FILE: sv/ccs_in_if.sv
// point channel: cone and clock angle
// depends on ccs_pkg
`timescale 1ns / 1ps

interface ccs_in_if;
    logic                              valid;
    logic                              ready;
    logic        [ccs_pkg::ANG_W-1:0]  cone_angle;
    logic signed [ccs_pkg::CLK_W-1:0]  clock_angle;

    modport source (output valid, output cone_angle, output clock_angle, input ready);
    modport sink   (input valid, input cone_angle, input clock_angle, output ready);
endinterface

FILE: sv/ccs_out_if.sv
// result channel: stereographic coordinates and flags
// depends on ccs_pkg
`timescale 1ns / 1ps

interface ccs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ccs_pkg::OUT_W-1:0]  x_coord;
    logic signed [ccs_pkg::OUT_W-1:0]  y_coord;
    logic                              inside_limit;
    logic                              saturated;

    modport source (output valid, output x_coord, output y_coord, output inside_limit,
                    output saturated, input ready);
    modport sink   (input valid, input x_coord, input y_coord, input inside_limit,
                    input saturated, output ready);
endinterface

FILE: sv/ccs_cfg_if.sv
// configuration write channel for the maximum excursion register
// depends on ccs_pkg
`timescale 1ns / 1ps

interface ccs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ccs_pkg::ANG_W-1:0]   max_excursion;

    modport source (output valid, output max_excursion, input ready);
    modport sink   (input valid, input max_excursion, output ready);
endinterface

FILE: sv/cone_clock_to_stereographic.sv
// cone/clock angle to stereographic projection, fully pipelined
// one point per cycle while the output is not stalled
// two cordic chains (16 stages), 32x32 multiply, two restoring dividers (21 stages)
// a stalled output freezes the whole pipe; bubbles ahead of it still advance only with it
// synchronous active-low reset clears valid bits and sets max excursion to pi
// depends on ccs_pkg, ccs_in_if, ccs_out_if, ccs_cfg_if
`timescale 1ns / 1ps

module cone_clock_to_stereographic (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccs_in_if.sink     i_pt,
    ccs_cfg_if.sink    i_cfg,
    ccs_out_if.source  o_res
);

    localparam int S  = ccs_pkg::CORDIC_STEPS;
    localparam int AW = ccs_pkg::AW;
    localparam int TW = ccs_pkg::TW;
    localparam int UW = ccs_pkg::UW;
    localparam int DW = ccs_pkg::DW;
    localparam int QB = ccs_pkg::QB;
    localparam int RW = ccs_pkg::RW;
    localparam int NS = ccs_pkg::N_STAGES;
    localparam int OW = ccs_pkg::OUT_W;

    logic                         en;
    logic [NS-1:0]                r_vld;
    logic [NS-1:0]                r_ins;
    logic [ccs_pkg::ANG_W-1:0]    r_max_exc;

    logic signed [AW-1:0] r_ang [0:1];
    logic signed [AW-1:0] r_cx  [0:1][0:S];
    logic signed [AW-1:0] r_cy  [0:1][0:S];
    logic signed [AW-1:0] r_cz  [0:1][0:S];
    logic                 r_neg [0:1][0:S];
    logic signed [TW-1:0] r_s   [0:1];
    logic signed [TW-1:0] r_c   [0:1];
    logic signed [UW-1:0] r_u   [0:1];
    logic signed [UW-1:0] r_den;
    logic [RW-1:0]        r_rem [0:1][0:QB];
    logic [QB-1:0]        r_quo [0:1][0:QB];
    logic [DW-1:0]        r_d   [0:1][0:QB];
    logic                 r_sgn [0:1][0:QB];
    logic                 r_zer [0:1][0:QB];
    logic                 r_ovf [0:1][0:QB];
    logic                 r_nz  [0:1][0:QB];
    logic signed [OW-1:0] r_o   [0:1];
    logic                 r_sat;

    assign en          = !r_vld[NS-1] || o_res.ready;
    assign i_pt.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_max_exc <= ccs_pkg::MAX_EXC_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_max_exc <= i_cfg.max_excursion;
            end
            if (en) begin
                r_vld <= {r_vld[NS-2:0], i_pt.valid};
            end
        end
    end

    // angle stage: declination, right ascension, 2pi wrap, inside-limit flag
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang[0] <= ccs_pkg::wrap_2pi(ccs_pkg::Q30_HALF_PI
                        - (AW'(i_pt.cone_angle) <<< 17));
            r_ang[1] <= ccs_pkg::wrap_2pi(AW'(i_pt.clock_angle) <<< 17);
            r_ins    <= {r_ins[NS-2:0], (i_pt.cone_angle < r_max_exc)};
        end
    end

    // pi reduction and cordic start
    for (genvar l = 0; l < 2; l++) begin : g_start
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cx[l][0] <= ccs_pkg::Q30_GAIN;
                r_cy[l][0] <= '0;
                if (r_ang[l] > ccs_pkg::Q30_HALF_PI) begin
                    r_cz[l][0]  <= r_ang[l] - ccs_pkg::Q30_PI;
                    r_neg[l][0] <= 1'b1;
                end else if (r_ang[l] < -ccs_pkg::Q30_HALF_PI) begin
                    r_cz[l][0]  <= r_ang[l] + ccs_pkg::Q30_PI;
                    r_neg[l][0] <= 1'b1;
                end else begin
                    r_cz[l][0]  <= r_ang[l];
                    r_neg[l][0] <= 1'b0;
                end
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        for (genvar k = 1; k <= S; k++) begin : g_cordic
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_neg[l][k] <= r_neg[l][k-1];
                    if (r_cz[l][k-1] >= 0) begin
                        r_cx[l][k] <= r_cx[l][k-1] - (r_cy[l][k-1] >>> (k-1));
                        r_cy[l][k] <= r_cy[l][k-1] + (r_cx[l][k-1] >>> (k-1));
                        r_cz[l][k] <= r_cz[l][k-1] - ccs_pkg::atan_q30(k-1);
                    end else begin
                        r_cx[l][k] <= r_cx[l][k-1] + (r_cy[l][k-1] >>> (k-1));
                        r_cy[l][k] <= r_cy[l][k-1] - (r_cx[l][k-1] >>> (k-1));
                        r_cz[l][k] <= r_cz[l][k-1] + ccs_pkg::atan_q30(k-1);
                    end
                end
            end
        end
    end

    // trig results, products, denominator
    logic signed [2*TW-1:0] w_p0;
    logic signed [2*TW-1:0] w_p1;
    assign w_p0 = r_c[0] * r_c[1];
    assign w_p1 = r_c[0] * r_s[1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                r_s[l] <= r_neg[l][S] ? TW'(-r_cy[l][S]) : TW'(r_cy[l][S]);
                r_c[l] <= r_neg[l][S] ? TW'(-r_cx[l][S]) : TW'(r_cx[l][S]);
            end
            r_u[0] <= w_p0[30+UW-1:30];
            r_u[1] <= w_p1[30+UW-1:30];
            r_den  <= UW'(ccs_pkg::Q30_ONE) + {r_s[0][TW-1], r_s[0]};
        end
    end

    // divider setup
    logic [UW-1:0] w_mag [0:1];
    logic [RW-1:0] w_num [0:1];
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_mag[l] = r_u[l][UW-1] ? UW'(-r_u[l]) : UW'(r_u[l]);
            w_num[l] = RW'(w_mag[l]) << ccs_pkg::OUT_FRAC_BITS;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_dset
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[l][0] <= w_num[l];
                r_quo[l][0] <= '0;
                r_d[l][0]   <= r_den[DW-1:0];
                r_sgn[l][0] <= r_u[l][UW-1];
                r_nz[l][0]  <= (r_u[l] != 0);
                r_zer[l][0] <= (r_den <= 0);
                r_ovf[l][0] <= (w_num[l] >= (RW'(r_den[DW-1:0]) << QB));
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_dlane
        for (genvar q = 1; q <= QB; q++) begin : g_div
            logic [RW-1:0] w_sub;
            assign w_sub = RW'(r_d[l][q-1]) << (QB - q);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_d[l][q]   <= r_d[l][q-1];
                    r_sgn[l][q] <= r_sgn[l][q-1];
                    r_nz[l][q]  <= r_nz[l][q-1];
                    r_zer[l][q] <= r_zer[l][q-1];
                    r_ovf[l][q] <= r_ovf[l][q-1];
                    if (r_rem[l][q-1] >= w_sub) begin
                        r_rem[l][q] <= r_rem[l][q-1] - w_sub;
                        r_quo[l][q] <= r_quo[l][q-1] | (QB'(1) << (QB - q));
                    end else begin
                        r_rem[l][q] <= r_rem[l][q-1];
                        r_quo[l][q] <= r_quo[l][q-1];
                    end
                end
            end
        end
    end

    // sign, clip, flags
    logic signed [OW-1:0] n_o   [0:1];
    logic                 n_lsat [0:1];
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_lsat[l] = 1'b1;
            if (r_zer[l][QB]) begin
                n_o[l] = !r_nz[l][QB] ? '0 : (r_sgn[l][QB] ? ccs_pkg::OUT_MIN
                                                             : ccs_pkg::OUT_MAX);
            end else if (r_sgn[l][QB]) begin
                if (r_ovf[l][QB] || r_quo[l][QB] > QB'(524288)) begin
                    n_o[l] = ccs_pkg::OUT_MIN;
                end else begin
                    n_o[l]    = OW'(-r_quo[l][QB]);
                    n_lsat[l] = 1'b0;
                end
            end else begin
                if (r_ovf[l][QB] || r_quo[l][QB] > QB'(524287)) begin
                    n_o[l] = ccs_pkg::OUT_MAX;
                end else begin
                    n_o[l]    = OW'(r_quo[l][QB]);
                    n_lsat[l] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o[0] <= n_o[0];
            r_o[1] <= n_o[1];
            r_sat  <= n_lsat[0] || n_lsat[1];
        end
    end

    assign o_res.valid        = r_vld[NS-1];
    assign o_res.x_coord      = r_o[0];
    assign o_res.y_coord      = r_o[1];
    assign o_res.inside_limit = r_ins[NS-1];
    assign o_res.saturated    = r_sat;

    a_ready_follows_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.ready == (!o_res.valid || o_res.ready))
        else $error("input ready does not follow output stall");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid straight after reset");

    a_div_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ccs_pkg::ST_OUT-1] && !r_zer[0][QB] && !r_ovf[0][QB])
            |-> (r_rem[0][QB] < RW'(r_d[0][QB])))
        else $error("x divider remainder not below divisor");

    a_div_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ccs_pkg::ST_OUT-1] && !r_zer[1][QB] && !r_ovf[1][QB])
            |-> (r_rem[1][QB] < RW'(r_d[1][QB])))
        else $error("y divider remainder not below divisor");

endmodule

FILE: sim/ccs_checker.sv
// checker for the cone/clock stereographic block: predicts each point's projection
// and compares transfers on the result channel; depends on ccs_pkg and the channel interfaces
`timescale 1ns / 1ps

module ccs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccs_in_if.sink      i_pt,
    ccs_cfg_if.sink     i_cfg,
    ccs_out_if.sink     i_res,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic signed [ccs_pkg::OUT_W-1:0] x;
        logic signed [ccs_pkg::OUT_W-1:0] y;
        logic                             in_lim;
        logic                             sat;
    } t_proj;

    t_proj                       proj_q[$];
    logic [ccs_pkg::ANG_W-1:0]   max_exc;
    int                          errors;
    int                          pending;

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_step(input int i);
        longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return tab[i];
        if (i <= 30) return longint'(1) << (30 - i);
        return 0;
    endfunction

    task automatic rotate(input longint ang, output longint s, output longint c);
        longint pi_q, x, y, z, dx, dy;
        bit     flip;
        pi_q = 64'sd3373259426;
        x = 652032874;
        y = 0;
        flip = 0;
        if (ang > pi_q) ang -= 64'sd6746518852;
        else if (ang < -pi_q) ang += 64'sd6746518852;
        if (ang > 64'sd1686629713) begin
            ang -= pi_q;
            flip = 1;
        end else if (ang < -64'sd1686629713) begin
            ang += pi_q;
            flip = 1;
        end
        z = ang;
        for (int i = 0; i < ccs_pkg::CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic logic signed [ccs_pkg::OUT_W-1:0] divide_clip(input longint num,
                                                                     input longint den,
                                                                     inout logic sat);
        longint q;
        if (den <= 0) begin
            sat = 1;
            if (num > 0) return ccs_pkg::OUT_MAX;
            if (num < 0) return ccs_pkg::OUT_MIN;
            return '0;
        end
        q = (num * (longint'(1) << ccs_pkg::OUT_FRAC_BITS)) / den;
        if (q > 524287) begin
            sat = 1; return ccs_pkg::OUT_MAX;
        end
        if (q < -524288) begin
            sat = 1; return ccs_pkg::OUT_MIN;
        end
        return q[ccs_pkg::OUT_W-1:0];
    endfunction

    task automatic predict_projection(input logic [ccs_pkg::ANG_W-1:0] cone,
                                      input logic signed [ccs_pkg::CLK_W-1:0] clk_ang);
        longint sd, cd, sr, cr, u0, u1, den;
        t_proj  p;
        p.sat = 0;
        rotate(64'sd1686629713 - (longint'(cone) <<< 17), sd, cd);
        rotate(longint'(clk_ang) <<< 17, sr, cr);
        u0 = floor_shr(cd * cr, 30);
        u1 = floor_shr(cd * sr, 30);
        den = 64'sd1073741824 + sd;
        p.x = divide_clip(u0, den, p.sat);
        p.y = divide_clip(u1, den, p.sat);
        p.in_lim = cone < max_exc;
        proj_q = {proj_q, p};
    endtask

    always @(posedge i_clk) begin
        t_proj e;
        if (!i_rst_n) begin
            max_exc <= ccs_pkg::MAX_EXC_RESET;
            proj_q.delete();
            errors = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) max_exc <= i_cfg.max_excursion;
            if (i_pt.valid && i_pt.ready) predict_projection(i_pt.cone_angle, i_pt.clock_angle);
            if (i_res.valid && i_res.ready) begin
                if (proj_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result x=%0d y=%0d",
                                               i_res.x_coord, i_res.y_coord);
                end else begin
                    e = proj_q.pop_front();
                    if (e.x !== i_res.x_coord || e.y !== i_res.y_coord ||
                        e.in_lim !== i_res.inside_limit || e.sat !== i_res.saturated) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch exp x=%0d y=%0d in=%0b sat=%0b",
                                      " got x=%0d y=%0d in=%0b sat=%0b"},
                                     e.x, e.y, e.in_lim, e.sat, i_res.x_coord,
                                     i_res.y_coord, i_res.inside_limit, i_res.saturated);
                    end
                end
            end
        end
        pending = proj_q.size();
    end

    assign o_errors  = errors;
    assign o_pending = pending;
endmodule

FILE: sim/tb.sv
// top of the cone/clock stereographic testbench: clock, reset, stimulus and verdict
// depends on ccs_pkg, the channel interfaces, the block and ccs_checker
`timescale 1ns / 1ps

module tb;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    int   send_idle, recv_stall;
    bit   hold_off;

    ccs_in_if  pt_if ();
    ccs_out_if res_if ();
    ccs_cfg_if cfg_if ();

    cone_clock_to_stereographic u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_if.sink), .i_cfg(cfg_if.sink),
        .o_res(res_if.source)
    );

    ccs_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_if.sink), .i_cfg(cfg_if.sink),
        .i_res(res_if.sink), .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 0; #10;
        i_clk = 1; #10;
    end

    // receiver stalls at random, or holds off entirely for a long stretch
    always @(posedge i_clk) begin
        res_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end

    initial begin
        hold_off = 0;
        wait (i_rst_n);
        repeat (380) @(posedge i_clk);
        hold_off = 1;
        repeat (200) @(posedge i_clk);
        hold_off = 0;
    end

    task automatic send_point(input logic [ccs_pkg::ANG_W-1:0] cone,
                              input logic signed [ccs_pkg::CLK_W-1:0] ca);
        while ($urandom_range(99) < send_idle) begin
            pt_if.valid <= 0;
            @(posedge i_clk);
        end
        pt_if.valid <= 1;
        pt_if.cone_angle <= cone;
        pt_if.clock_angle <= ca;
        do @(posedge i_clk); while (!pt_if.ready);
    endtask

    task automatic drain_pipe();
        pt_if.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_max_excursion(input logic [ccs_pkg::ANG_W-1:0] v);
        cfg_if.valid <= 1;
        cfg_if.max_excursion <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 0;
    endtask

    task automatic random_points(input int n);
        logic [ccs_pkg::ANG_W-1:0]        c;
        logic signed [ccs_pkg::CLK_W-1:0] a;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: begin
                    c = ccs_pkg::ANG_W'($urandom);
                    a = ccs_pkg::CLK_W'($urandom);
                end
                1: begin
                    c = ccs_pkg::ANG_W'($urandom_range(25736, 25000));
                    a = ccs_pkg::CLK_W'(int'($urandom_range(51472)) - 25736);
                end
                default: begin
                    c = ccs_pkg::ANG_W'($urandom_range(25736));
                    a = ccs_pkg::CLK_W'(int'($urandom_range(51472)) - 25736);
                end
            endcase
            send_point(c, a);
        end
    endtask

    initial begin
        pt_if.valid = 0;
        pt_if.cone_angle = '0;
        pt_if.clock_angle = '0;
        cfg_if.valid = 0;
        cfg_if.max_excursion = '0;
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, pole, wrap beyond pi, zero denominator
        send_point(15'd0, 16'sd0);
        send_point(15'd25736, 16'sd0);
        send_point(15'd25736, 16'sd12868);
        send_point(15'd25735, 16'sd100);
        send_point(15'd25700, -16'sd5000);
        send_point(15'd32767, 16'sd32767);
        send_point(15'd32767, 16'sh8000);
        send_point(15'd0, 16'sh8000);
        send_point(15'd12868, 16'sd25736);
        send_point(15'd12868, -16'sd25736);
        send_point(15'd20000, 16'sd32000);
        send_point(15'd30000, -16'sd30000);
        send_point(15'h5555, 16'sh5555);
        send_point(15'h2AAA, 16'shAAAA);
        drain_pipe();
        set_max_excursion(15'd0);
        send_point(15'd0, 16'sd1);
        send_point(15'd1, 16'sd1);
        drain_pipe();
        set_max_excursion(15'h7FFF);
        send_point(15'h7FFE, 16'sd0);
        send_point(15'h7FFF, 16'sd0);
        drain_pipe();
        set_max_excursion(15'd12868);
        random_points(140);
        drain_pipe();
        send_idle = 76;
        set_max_excursion(15'd25736);
        random_points(130);
        drain_pipe();
        send_idle = 0;
        recv_stall = 76;
        set_max_excursion(ccs_pkg::ANG_W'($urandom_range(25736)));
        random_points(140);
        drain_pipe();
        send_idle = 24;
        recv_stall = 24;
        random_points(130);
        drain_pipe();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
